// ----- rtl/core/mlfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, codes and record types of the multilevel feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_BURSTS = 8;
  localparam int MAX_LEVELS = 8;

  localparam int PID_W   = $clog2(MAX_PROCS);
  localparam int BI_W    = $clog2(MAX_BURSTS);
  localparam int LVL_W   = $clog2(MAX_LEVELS);
  localparam int CNT_W   = PID_W + 1;
  localparam int NLV_W   = LVL_W + 1;
  localparam int FIFO_AW = LVL_W + PID_W;
  localparam int BT_AW   = PID_W + BI_W;

  localparam logic [32:0] RESP_UNSET = {33{1'b1}};

  // Input operation codes
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ARRIVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_QUANTUM = 1'b0,
    CFG_LEVELS  = 1'b1
  } cfg_idx_t;

  // Per-process record held in the process memory
  typedef struct packed {
    logic [31:0]     arrival;
    logic [31:0]     wait_cnt;
    logic [32:0]     resp;
    logic [15:0]     turns;
    logic [15:0]     expiries;
    logic [BI_W-1:0] pos;
  } proc_rec_t;

  localparam int REC_W = $bits(proc_rec_t);

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    sat16_inc = (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

endpackage

// ----- rtl/core/mlfq_ram.sv -----
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/multilevel_feedback_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue scheduler with quantum-based demotion.
// ----------------------------------------------------------------------------
// Load and arrive beats leave busy low, and the result strobe follows in the
// next cycle. A tick beat fetches the running process record and its burst
// (only while a process runs), updates and requeues it, dispatches the next
// process through the level FIFO memory (only when none runs and a level is
// nonempty), and walks over every slot of the process memory to add waiting
// time, one slot per cycle. The result strobe comes in the same cycle that busy
// falls and cannot be held off; configuration writes are always taken.
module multilevel_feedback_queue_scheduler
  import mlfq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_proc_id,
  input  logic [2:0]  in_burst_index,
  input  logic [15:0] in_burst_length,
  input  logic        in_last_burst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // result
  output logic        out_valid,
  output logic [31:0] out_now,
  output logic        out_run_valid,
  output logic [3:0]  out_run_id,
  output logic [2:0]  out_run_level,
  output logic        out_done_valid,
  output logic [3:0]  out_done_id,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic [31:0] out_response,
  output logic [15:0] out_cpu_turns,
  output logic [15:0] out_preemptions
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_REC   = 9'b000000010,
    S_RD_BURST = 9'b000000100,
    S_EVAL     = 9'b000001000,
    S_DISP     = 9'b000010000,
    S_DISP_REC = 9'b000100000,
    S_DISP_UPD = 9'b001000000,
    S_WALK     = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0]      quantum_r;
  logic [3:0]       levels_r;

  // scheduler state
  logic [MAX_PROCS-1:0]  active_r;
  logic [BI_W-1:0]       final_r [MAX_PROCS];
  logic [PID_W-1:0]      head_r  [MAX_LEVELS];
  logic [CNT_W-1:0]      count_r [MAX_LEVELS];
  logic                  running_r;
  logic [PID_W-1:0]      cur_r;
  logic [LVL_W-1:0]      cur_lvl_r;
  logic [15:0]           qleft_r;
  logic [31:0]           time_r;
  proc_rec_t             rec_r;
  logic [LVL_W-1:0]      pick_r;
  logic [CNT_W-1:0]      walk_r;

  // finish report of the current tick
  logic                  d_valid_r;
  logic [PID_W-1:0]      d_id_r;
  logic [31:0]           d_turn_r;
  logic [31:0]           d_wait_r;
  logic [31:0]           d_resp_r;
  logic [15:0]           d_cpu_r;
  logic [15:0]           d_pre_r;

  // memory ports
  logic                  prec_we;
  logic [PID_W-1:0]      prec_waddr, prec_raddr;
  proc_rec_t             prec_wdata, prec_rdata;
  logic                  fifo_we;
  logic [FIFO_AW-1:0]    fifo_waddr, fifo_raddr;
  logic [PID_W-1:0]      fifo_wdata, fifo_rdata;
  logic                  bt_we;
  logic [BT_AW-1:0]      bt_waddr, bt_raddr;
  logic [15:0]           bt_wdata, bt_rdata;

  mlfq_ram #(.WIDTH(REC_W), .DEPTH(MAX_PROCS)) u_proc_mem (
    .clk, .we(prec_we), .waddr(prec_waddr), .wdata(prec_wdata),
    .raddr(prec_raddr), .rdata(prec_rdata)
  );

  mlfq_ram #(.WIDTH(PID_W), .DEPTH(MAX_LEVELS * MAX_PROCS)) u_fifo_mem (
    .clk, .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
    .raddr(fifo_raddr), .rdata(fifo_rdata)
  );

  mlfq_ram #(.WIDTH(16), .DEPTH(MAX_PROCS * MAX_BURSTS)) u_burst_mem (
    .clk, .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
    .raddr(bt_raddr), .rdata(bt_rdata)
  );

  // handshake
  logic accept;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // levels in use and demotion target
  logic [NLV_W-1:0] lv_use;
  logic [NLV_W-1:0] next_lvl;
  always_comb begin
    if (levels_r == '0) begin
      lv_use = NLV_W'(1);
    end else if (NLV_W'(levels_r) > NLV_W'(MAX_LEVELS)) begin
      lv_use = NLV_W'(MAX_LEVELS);
    end else begin
      lv_use = NLV_W'(levels_r);
    end
    next_lvl = NLV_W'(cur_lvl_r) + NLV_W'(1);
    if (next_lvl > lv_use - NLV_W'(1)) begin
      next_lvl = lv_use - NLV_W'(1);
    end
  end

  // lowest-numbered (highest-priority) nonempty level
  logic             any_ready;
  logic [LVL_W-1:0] pick_lvl;
  always_comb begin
    any_ready = 1'b0;
    pick_lvl  = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        any_ready = 1'b1;
        pick_lvl  = LVL_W'(l);
      end
    end
  end

  // evaluation of the running process
  logic [15:0]      q_dec, b_dec;
  logic             expired, ended, finish, push_ok;
  logic [LVL_W-1:0] push_lvl;
  proc_rec_t        eval_rec;
  always_comb begin
    q_dec    = (qleft_r != '0) ? qleft_r - 16'd1 : qleft_r;
    b_dec    = (bt_rdata != '0) ? bt_rdata - 16'd1 : bt_rdata;
    expired  = (q_dec == '0);
    ended    = (b_dec == '0);
    finish   = ended && ((rec_r.pos == final_r[cur_r]) ||
                         (rec_r.pos == BI_W'(MAX_BURSTS - 1)));
    push_lvl = next_lvl[LVL_W-1:0];
    push_ok  = (count_r[push_lvl] != CNT_W'(MAX_PROCS));
    eval_rec = rec_r;
    if (expired) begin
      eval_rec.expiries = sat16_inc(rec_r.expiries);
    end
    if (ended && !finish) begin
      eval_rec.pos = rec_r.pos + BI_W'(1);
    end
  end

  // dispatch record update
  proc_rec_t disp_rec;
  always_comb begin
    disp_rec       = prec_rdata;
    disp_rec.turns = sat16_inc(prec_rdata.turns);
    if (prec_rdata.resp == RESP_UNSET) begin
      disp_rec.resp = {1'b0, prec_rdata.wait_cnt};
    end
  end

  // waiting walk
  logic [PID_W-1:0] walk_wi;
  proc_rec_t        walk_rec;
  logic             walk_inc;
  always_comb begin
    walk_wi  = PID_W'(walk_r - CNT_W'(1));
    walk_rec = prec_rdata;
    walk_rec.wait_cnt = prec_rdata.wait_cnt + 32'd1;
    walk_inc = (walk_r != '0) && active_r[walk_wi] &&
               !(running_r && (walk_wi == cur_r)) &&
               (prec_rdata.wait_cnt != 32'hFFFF_FFFF);
  end

  // arrival record
  proc_rec_t arr_rec;
  always_comb begin
    arr_rec          = '0;
    arr_rec.arrival  = time_r;
    arr_rec.resp     = RESP_UNSET;
  end

  // memory port control
  always_comb begin
    prec_we    = 1'b0;
    prec_waddr = cur_r;
    prec_wdata = eval_rec;
    prec_raddr = cur_r;
    fifo_we    = 1'b0;
    fifo_waddr = {push_lvl, head_r[push_lvl] + PID_W'(count_r[push_lvl])};
    fifo_wdata = cur_r;
    fifo_raddr = {pick_lvl, head_r[pick_lvl]};
    bt_we      = 1'b0;
    bt_waddr   = {cur_r, rec_r.pos};
    bt_wdata   = b_dec;
    bt_raddr   = {cur_r, prec_rdata.pos};
    unique case (state_r)
      S_IDLE: begin
        if (accept && func_t'(in_func) == FUNC_LOAD) begin
          bt_we    = 1'b1;
          bt_waddr = {in_proc_id, in_burst_index};
          bt_wdata = in_burst_length;
        end
        if (accept && func_t'(in_func) == FUNC_ARRIVE && !active_r[in_proc_id]) begin
          prec_we    = 1'b1;
          prec_waddr = in_proc_id;
          prec_wdata = arr_rec;
          fifo_we    = (count_r[0] != CNT_W'(MAX_PROCS));
          fifo_waddr = {LVL_W'(0), head_r[0] + PID_W'(count_r[0])};
          fifo_wdata = in_proc_id;
        end
      end
      S_RD_REC, S_RD_BURST: ;
      S_EVAL: begin
        bt_we   = 1'b1;
        prec_we = 1'b1;
        fifo_we = (expired || ended) && !finish && push_ok;
      end
      S_DISP: ;
      S_DISP_REC: begin
        prec_raddr = fifo_rdata;
      end
      S_DISP_UPD: begin
        prec_we    = 1'b1;
        prec_waddr = cur_r;
        prec_wdata = disp_rec;
      end
      S_WALK: begin
        prec_raddr = walk_r[PID_W-1:0];
        prec_we    = walk_inc;
        prec_waddr = walk_wi;
        prec_wdata = walk_rec;
      end
      S_FIN: ;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && func_t'(in_func) == FUNC_TICK) begin
          state_nxt = running_r ? S_RD_REC : S_DISP;
        end
      end
      S_RD_REC:   state_nxt = S_RD_BURST;
      S_RD_BURST: state_nxt = S_EVAL;
      S_EVAL:     state_nxt = S_DISP;
      S_DISP:     state_nxt = (!running_r && any_ready) ? S_DISP_REC : S_WALK;
      S_DISP_REC: state_nxt = S_DISP_UPD;
      S_DISP_UPD: state_nxt = S_WALK;
      S_WALK:     state_nxt = (walk_r == CNT_W'(MAX_PROCS)) ? S_FIN : S_WALK;
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // control and scheduler registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      quantum_r <= 16'd4;
      levels_r  <= 4'd3;
      active_r  <= '0;
      running_r <= 1'b0;
      cur_r     <= '0;
      cur_lvl_r <= '0;
      qleft_r   <= '0;
      time_r    <= '0;
      walk_r    <= '0;
      d_valid_r <= 1'b0;
      out_valid <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;

      // take configuration beats
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_QUANTUM) begin
          quantum_r <= cfg_data;
        end else begin
          levels_r <= cfg_data[3:0];
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            d_valid_r <= 1'b0;
            walk_r    <= '0;
            if (func_t'(in_func) == FUNC_ARRIVE && !active_r[in_proc_id]) begin
              active_r[in_proc_id] <= 1'b1;
              if (count_r[0] != CNT_W'(MAX_PROCS)) begin
                count_r[0] <= count_r[0] + CNT_W'(1);
              end
            end
            if (func_t'(in_func) != FUNC_TICK) begin
              out_valid <= 1'b1;
            end
          end
        end
        S_RD_REC, S_RD_BURST: ;
        S_EVAL: begin
          qleft_r <= q_dec;
          if (expired || ended) begin
            running_r <= 1'b0;
            if (finish) begin
              active_r[cur_r] <= 1'b0;
              d_valid_r       <= 1'b1;
            end else if (push_ok) begin
              count_r[push_lvl] <= count_r[push_lvl] + CNT_W'(1);
            end
          end
        end
        S_DISP: begin
          if (!running_r && any_ready) begin
            head_r[pick_lvl]  <= head_r[pick_lvl] + PID_W'(1);
            count_r[pick_lvl] <= count_r[pick_lvl] - CNT_W'(1);
          end
        end
        S_DISP_REC: begin
          cur_r <= fifo_rdata;
        end
        S_DISP_UPD: begin
          running_r <= 1'b1;
          cur_lvl_r <= pick_r;
          qleft_r   <= (quantum_r != '0) ? quantum_r : 16'd1;
        end
        S_WALK: begin
          walk_r <= walk_r + CNT_W'(1);
        end
        S_FIN: begin
          out_valid <= 1'b1;
          if (time_r != 32'hFFFF_FFFF) begin
            time_r <= time_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && func_t'(in_func) == FUNC_LOAD && in_last_burst) begin
      final_r[in_proc_id] <= in_burst_index;
    end
    if (state_r == S_RD_BURST) begin
      rec_r <= prec_rdata;
    end
    if (state_r == S_DISP) begin
      pick_r <= pick_lvl;
    end
    if (state_r == S_EVAL) begin
      d_id_r   <= cur_r;
      d_turn_r <= (time_r >= rec_r.arrival) ? time_r - rec_r.arrival : 32'd0;
      d_wait_r <= rec_r.wait_cnt;
      d_resp_r <= (rec_r.resp == RESP_UNSET) ? 32'd0 : rec_r.resp[31:0];
      d_cpu_r  <= rec_r.turns;
      d_pre_r  <= eval_rec.expiries;
    end
  end

  // result beat
  logic fin_done, fin_run, take_out;
  always_comb begin
    fin_run  = (state_r == S_FIN) ? running_r : (running_r && !(expired && 1'b0));
    fin_done = (state_r == S_FIN) && d_valid_r;
    take_out = (state_r == S_FIN) ||
               (state_r == S_IDLE && accept && func_t'(in_func) != FUNC_TICK);
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_now         <= time_r;
      out_run_valid   <= fin_run;
      out_run_id      <= fin_run ? cur_r : '0;
      out_run_level   <= fin_run ? cur_lvl_r : '0;
      out_done_valid  <= fin_done;
      out_done_id     <= fin_done ? d_id_r : '0;
      out_turnaround  <= fin_done ? d_turn_r : '0;
      out_waiting     <= fin_done ? d_wait_r : '0;
      out_response    <= fin_done ? d_resp_r : '0;
      out_cpu_turns   <= fin_done ? d_cpu_r : '0;
      out_preemptions <= fin_done ? d_pre_r : '0;
    end
  end

  // a running process is always an active one
  a_run_active: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> active_r[cur_r])
    else $error("running process is not active");

  // a dispatched process always holds a nonzero quantum between beats
  a_quantum_live: assert property (@(posedge clk) disable iff (!rst_n)
    (running_r && state_r == S_IDLE) |-> (qleft_r != '0))
    else $error("running process with empty quantum");

  // a finished process is not reported on the CPU in the same beat
  a_done_not_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_valid) |-> !(out_run_valid && out_run_id == out_done_id))
    else $error("finished process still running");

endmodule
